/* src/cms_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CAN message serializer package
// Shared types, constants and the ASCII hex digit table.
// ----------------------------------------------------------------------------
package cms_pkg;

    localparam logic [7:0] SYNC_BYTE_0  = 8'hBE;
    localparam logic [7:0] SYNC_BYTE_1  = 8'hEF;
    localparam logic [7:0] CRC_POLY     = 8'h1D;
    localparam logic [7:0] CRC_INIT     = 8'hFF;
    localparam logic [7:0] ASCII_SPACE  = 8'h20;
    localparam logic [7:0] ASCII_NL     = 8'h0A;
    localparam int unsigned DATA_BYTES  = 8;

    // Configuration register byte addresses.
    localparam logic [3:0] ADDR_TEXT_FORMAT = 4'h0;
    localparam logic [3:0] ADDR_VALID_ONLY  = 4'h4;
    localparam logic [3:0] ADDR_CRC_ENABLE  = 4'h8;

    // Control from the sequencer to the shared CRC unit.
    typedef struct packed {
        logic init;
        logic feed;
    } t_crc_ctl;

    // Uppercase ASCII hex digit for one nibble.
    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] c;
        unique case (nib)
            4'h0: c = 8'h30;
            4'h1: c = 8'h31;
            4'h2: c = 8'h32;
            4'h3: c = 8'h33;
            4'h4: c = 8'h34;
            4'h5: c = 8'h35;
            4'h6: c = 8'h36;
            4'h7: c = 8'h37;
            4'h8: c = 8'h38;
            4'h9: c = 8'h39;
            4'hA: c = 8'h41;
            4'hB: c = 8'h42;
            4'hC: c = 8'h43;
            4'hD: c = 8'h44;
            4'hE: c = 8'h45;
            default: c = 8'h46;
        endcase
        return c;
    endfunction

endpackage

/* src/cms_crc8.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CRC-8 accumulator
// Running CRC-8 (polynomial 0x1D) updated by one byte per cycle while fed.
// ----------------------------------------------------------------------------
module cms_crc8
    import cms_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_crc_ctl   i_ctl,
    input  logic [7:0] i_byte,
    output logic [7:0] o_crc
);

    logic [7:0] r_crc;
    logic [7:0] n_crc;

    // Eight shift-and-reduce steps of the MSB-first CRC.
    always_comb begin
        logic [7:0] c;
        c = r_crc ^ i_byte;
        for (int k = 0; k < 8; k++) begin
            c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
        end
        n_crc = c;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc <= CRC_INIT;
        end else if (i_ctl.init) begin
            r_crc <= CRC_INIT;
        end else if (i_ctl.feed) begin
            r_crc <= n_crc;
        end
    end

    assign o_crc = r_crc;

endmodule

/* src/can_message_serializer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CAN message serializer
// Turns one CAN message into a framed binary or hex text byte stream.
// ----------------------------------------------------------------------------
// Usage:
// A message transaction on the s_axis side carries the id, index byte,
// frame length and eight payload bytes; tuser holds the index-used flag.
// The block answers with a burst of bytes on the m_axis side, tlast set on
// the final one. Binary mode sends 0xBE 0xEF, the id low and high bytes, the
// index byte and D data bytes, plus a CRC byte when enabled (5+D or 6+D
// bytes). Text mode sends 7+2D characters, three more with the CRC, and a
// newline (up to 27). D is 8, or the valid byte count when valid_only is set.
// One byte is produced per cycle, unless the output register is full and
// m_axis_tready is low, by a sequencer that walks the fields and drives a
// single shared CRC-8 unit; s_axis_tready is low while a message is sent.
// The first byte reaches the m_axis side through the sequencer phase
// register and then the output register.
// The output register lets the next message be accepted while the last byte
// still waits; when it is full and m_axis_tready is low the sequencer holds.
// Reset empties the output register, idles the sequencer and clears the
// three configuration registers, which the APB port writes and reads back.
// ----------------------------------------------------------------------------
module can_message_serializer
    import cms_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Message input
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // can_id[10:0], frame_length[14:11], index_byte[22:15], payload[86:23]
    input  logic [87:0] s_axis_tdata,
    // index_used[0]
    input  logic        s_axis_tuser,
    // Byte output
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // out_byte[7:0]
    output logic [7:0]  m_axis_tdata,
    output logic        m_axis_tlast,
    // Configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    typedef enum logic [4:0] {
        PH_IDLE,
        PH_SYNC0, PH_SYNC1, PH_ID_LO, PH_ID_HI, PH_IDX, PH_BDATA, PH_BCRC,
        PH_TID2, PH_TID1, PH_TID0, PH_TSP1, PH_TIDXH, PH_TIDXL, PH_TSP2,
        PH_TDATAH, PH_TDATAL, PH_TCRCSP, PH_TCRCH, PH_TCRCL, PH_TNL
    } t_phase;

    // Configuration registers.
    logic r_text_format;
    logic r_valid_only;
    logic r_crc_enable;

    // Held message and sequencer state.
    t_phase      r_phase;
    logic [10:0] r_id;
    logic [7:0]  r_idx;
    logic [63:0] r_data;
    logic [3:0]  r_dleft;

    // Output register.
    logic       r_mvalid;
    logic [7:0] r_mbyte;
    logic       r_mlast;

    t_phase      n_phase;
    logic [63:0] n_data;
    logic [3:0]  n_dleft;
    logic [7:0]  n_byte;
    logic        n_feed;

    logic       accept;
    logic       step;
    logic       cfg_wr;
    logic       used;
    logic [3:0] flen;
    logic [3:0] plen_raw;
    logic [3:0] plen;
    logic [7:0] crc_val;
    logic [7:0] crc_fin;
    t_phase     tail_bin;
    t_phase     tail_txt;
    t_crc_ctl   crc_ctl;

    assign s_axis_tready = (r_phase == PH_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign step          = (r_phase != PH_IDLE) && (!r_mvalid || m_axis_tready);

    // Data byte count: frame length minus the index byte, floored at zero
    // and capped at eight.
    assign used     = s_axis_tuser;
    assign flen     = s_axis_tdata[14:11];
    assign plen_raw = (used && flen == 4'd0) ? 4'd0 : (flen - {3'b000, used});
    assign plen     = (plen_raw > 4'(DATA_BYTES)) ? 4'(DATA_BYTES) : plen_raw;

    assign crc_fin  = ~crc_val;
    assign tail_bin = r_crc_enable ? PH_BCRC : PH_IDLE;
    assign tail_txt = r_crc_enable ? PH_TCRCSP : PH_TNL;

    // Byte selection and next phase. Data bytes leave from the bottom of
    // r_data, which shifts down one byte per data byte sent.
    always_comb begin
        n_phase = r_phase;
        n_data  = r_data;
        n_dleft = r_dleft;
        n_byte  = 8'h00;
        n_feed  = 1'b0;
        unique case (r_phase)
            PH_IDLE: begin
                n_phase = PH_IDLE;
            end
            PH_SYNC0: begin
                n_byte  = SYNC_BYTE_0;
                n_phase = PH_SYNC1;
            end
            PH_SYNC1: begin
                n_byte  = SYNC_BYTE_1;
                n_phase = PH_ID_LO;
            end
            PH_ID_LO: begin
                n_byte  = r_id[7:0];
                n_feed  = 1'b1;
                n_phase = PH_ID_HI;
            end
            PH_ID_HI: begin
                n_byte  = {5'b00000, r_id[10:8]};
                n_feed  = 1'b1;
                n_phase = PH_IDX;
            end
            PH_IDX: begin
                n_byte  = r_idx;
                n_feed  = 1'b1;
                n_phase = (r_dleft != 4'd0) ? PH_BDATA : tail_bin;
            end
            PH_BDATA: begin
                n_byte  = r_data[7:0];
                n_feed  = 1'b1;
                n_data  = {8'h00, r_data[63:8]};
                n_dleft = r_dleft - 4'd1;
                n_phase = (r_dleft > 4'd1) ? PH_BDATA : tail_bin;
            end
            PH_BCRC: begin
                n_byte  = crc_fin;
                n_phase = PH_IDLE;
            end
            PH_TID2: begin
                n_byte  = hex_char({1'b0, r_id[10:8]});
                n_feed  = 1'b1;
                n_phase = PH_TID1;
            end
            PH_TID1: begin
                n_byte  = hex_char(r_id[7:4]);
                n_feed  = 1'b1;
                n_phase = PH_TID0;
            end
            PH_TID0: begin
                n_byte  = hex_char(r_id[3:0]);
                n_feed  = 1'b1;
                n_phase = PH_TSP1;
            end
            PH_TSP1: begin
                n_byte  = ASCII_SPACE;
                n_feed  = 1'b1;
                n_phase = PH_TIDXH;
            end
            PH_TIDXH: begin
                n_byte  = hex_char(r_idx[7:4]);
                n_feed  = 1'b1;
                n_phase = PH_TIDXL;
            end
            PH_TIDXL: begin
                n_byte  = hex_char(r_idx[3:0]);
                n_feed  = 1'b1;
                n_phase = PH_TSP2;
            end
            PH_TSP2: begin
                n_byte  = ASCII_SPACE;
                n_feed  = 1'b1;
                n_phase = (r_dleft != 4'd0) ? PH_TDATAH : tail_txt;
            end
            PH_TDATAH: begin
                n_byte  = hex_char(r_data[7:4]);
                n_feed  = 1'b1;
                n_phase = PH_TDATAL;
            end
            PH_TDATAL: begin
                n_byte  = hex_char(r_data[3:0]);
                n_feed  = 1'b1;
                n_data  = {8'h00, r_data[63:8]};
                n_dleft = r_dleft - 4'd1;
                n_phase = (r_dleft > 4'd1) ? PH_TDATAH : tail_txt;
            end
            PH_TCRCSP: begin
                n_byte  = ASCII_SPACE;
                n_phase = PH_TCRCH;
            end
            PH_TCRCH: begin
                n_byte  = hex_char(crc_fin[7:4]);
                n_phase = PH_TCRCL;
            end
            PH_TCRCL: begin
                n_byte  = hex_char(crc_fin[3:0]);
                n_phase = PH_TNL;
            end
            PH_TNL: begin
                n_byte  = ASCII_NL;
                n_phase = PH_IDLE;
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
    end

    // The CRC restarts with each accepted message and takes each covered
    // byte in the cycle it moves into the output register.
    assign crc_ctl.init = accept;
    assign crc_ctl.feed = step && n_feed;

    cms_crc8 u_crc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (crc_ctl),
        .i_byte  (n_byte),
        .o_crc   (crc_val)
    );

    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_IDLE;
            r_mvalid      <= 1'b0;
            r_text_format <= 1'b0;
            r_valid_only  <= 1'b0;
            r_crc_enable  <= 1'b0;
        end else begin
            if (cfg_wr) begin
                unique case (paddr)
                    ADDR_TEXT_FORMAT: r_text_format <= pwdata[0];
                    ADDR_VALID_ONLY:  r_valid_only  <= pwdata[0];
                    ADDR_CRC_ENABLE:  r_crc_enable  <= pwdata[0];
                    default: ;
                endcase
            end
            if (accept) begin
                r_id    <= s_axis_tdata[10:0];
                r_idx   <= used ? s_axis_tdata[22:15] : 8'h00;
                r_data  <= s_axis_tdata[86:23];
                r_dleft <= r_valid_only ? plen : 4'(DATA_BYTES);
                r_phase <= r_text_format ? PH_TID2 : PH_SYNC0;
            end else if (step) begin
                r_phase <= n_phase;
                r_data  <= n_data;
                r_dleft <= n_dleft;
            end
            if (step) begin
                r_mvalid <= 1'b1;
                r_mbyte  <= n_byte;
                r_mlast  <= (n_phase == PH_IDLE);
            end else if (m_axis_tready) begin
                r_mvalid <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = r_mvalid;
    assign m_axis_tdata  = r_mbyte;
    assign m_axis_tlast  = r_mlast;

    assign pready = 1'b1;

    always_comb begin
        unique case (paddr)
            ADDR_TEXT_FORMAT: prdata = {31'd0, r_text_format};
            ADDR_VALID_ONLY:  prdata = {31'd0, r_valid_only};
            ADDR_CRC_ENABLE:  prdata = {31'd0, r_crc_enable};
            default:          prdata = 32'd0;
        endcase
    end

`ifndef SYNTHESIS
    // A message occupies the sequencer for at least one byte.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !s_axis_tready)
        else $error("sequencer ready right after accepting a message");

    // The data byte counter never exceeds the payload size.
    a_dleft_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != PH_IDLE) |-> (r_dleft <= 4'(DATA_BYTES)))
        else $error("data byte counter out of range");

    // Data phases are entered only with bytes left to send.
    a_data_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_BDATA || r_phase == PH_TDATAH || r_phase == PH_TDATAL)
            |-> (r_dleft != 4'd0))
        else $error("data phase with no data bytes left");

    // A CRC byte is only produced when the CRC is enabled.
    a_crc_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_BCRC || r_phase == PH_TCRCSP) |-> r_crc_enable)
        else $error("CRC phase while CRC disabled");
`endif

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CAN message serializer testbench
// Drives messages into the serializer, predicts every byte burst (binary
// framing, hex text, CRC-8) in a local model or takes it from a table row,
// and compares each output byte and its tlast flag. A directed table comes
// first, then random traffic in every register setting, random gaps both sides.
// ----------------------------------------------------------------------------
module tb;
    import cms_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 1000000;
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned PHASE_ITEMS  = 25;

    // One row of the directed table. A nonzero exp_len means the burst is
    // typed in below, first byte highest among the low exp_len bytes of exp_vec.
    typedef struct packed {
        logic         text;
        logic         vonly;
        logic         crc;
        logic [10:0]  id;
        logic         used;
        logic [3:0]   flen;
        logic [7:0]   idx;
        logic [63:0]  payload;
        logic [4:0]   exp_len;
        logic [215:0] exp_vec;
    } msg_row_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [87:0] s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;
    logic        m_axis_tlast;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // Local copy of the configuration registers.
    logic cfg_text = 1'b0;
    logic cfg_vonly = 1'b0;
    logic cfg_crc = 1'b0;

    // Expected output bytes, {tlast, data}, oldest first.
    logic [8:0] pending_bytes[$];
    logic [7:0] msg_crc;
    msg_row_t   directed_rows[$];

    int  err_cnt = 0;
    int  msg_count = 0;
    int  byte_count = 0;
    int  setting_count = 0;
    int  cycle_count = 0;
    bit  hold_req = 1'b0;
    bit  quiet_phase = 1'b0;

    can_message_serializer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #4 i_clk = ~i_clk;

    function void flag_error(input string msg);
        err_cnt++;
        if (err_cnt <= 10) begin
            $display("MISMATCH: %s", msg);
        end
    endfunction

    // Mostly short gaps, a few long ones.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [7:0] ascii_hex(input logic [3:0] nib);
        if (nib < 4'd10) return 8'h30 + {4'h0, nib};
        return 8'h41 + {4'h0, nib} - 8'd10;
    endfunction

    // Appends one expected byte; the CRC-8 SAE J1850 runs MSB first.
    function void put_byte(input logic [7:0] b, input bit feed);
        logic [7:0] c;
        if (feed) begin
            c = msg_crc ^ b;
            for (int k = 0; k < 8; k++) begin
                c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
            end
            msg_crc = c;
        end
        pending_bytes.push_back({1'b0, b});
    endfunction

    function void put_hex(input logic [7:0] b, input bit feed);
        put_byte(ascii_hex(b[7:4]), feed);
        put_byte(ascii_hex(b[3:0]), feed);
    endfunction

    // Builds the byte burst that one message must produce under the current
    // configuration and queues it.
    function void predict_message(input logic [10:0] id, input logic used,
                                  input logic [3:0] flen, input logic [7:0] idx,
                                  input logic [63:0] payload);
        int         plen;
        int         count;
        logic [7:0] sent_idx;
        plen = (flen >= used) ? int'(flen) - int'(used) : 0;
        if (plen > 8) plen = 8;
        count = cfg_vonly ? plen : 8;
        sent_idx = used ? idx : 8'h00;
        msg_crc = CRC_INIT;
        if (!cfg_text) begin
            put_byte(SYNC_BYTE_0, 1'b0);
            put_byte(SYNC_BYTE_1, 1'b0);
            put_byte(id[7:0], 1'b1);
            put_byte({5'b0, id[10:8]}, 1'b1);
            put_byte(sent_idx, 1'b1);
            for (int i = 0; i < count; i++) put_byte(payload[8*i +: 8], 1'b1);
            if (cfg_crc) put_byte(~msg_crc, 1'b0);
        end else begin
            put_byte(ascii_hex({1'b0, id[10:8]}), 1'b1);
            put_byte(ascii_hex(id[7:4]), 1'b1);
            put_byte(ascii_hex(id[3:0]), 1'b1);
            put_byte(ASCII_SPACE, 1'b1);
            put_hex(sent_idx, 1'b1);
            put_byte(ASCII_SPACE, 1'b1);
            for (int i = 0; i < count; i++) put_hex(payload[8*i +: 8], 1'b1);
            if (cfg_crc) begin
                put_byte(ASCII_SPACE, 1'b0);
                put_hex(~msg_crc, 1'b0);
            end
            put_byte(ASCII_NL, 1'b0);
        end
        pending_bytes[$] = {1'b1, pending_bytes[$][7:0]};
    endfunction

    function automatic msg_row_t make_row(input logic t, input logic v, input logic c,
                                          input logic [10:0] id, input logic used,
                                          input logic [3:0] flen, input logic [7:0] idx,
                                          input logic [63:0] payload, input int exp_len,
                                          input logic [215:0] exp_vec);
        msg_row_t r;
        r.text = t;
        r.vonly = v;
        r.crc = c;
        r.id = id;
        r.used = used;
        r.flen = flen;
        r.idx = idx;
        r.payload = payload;
        r.exp_len = exp_len[4:0];
        r.exp_vec = exp_vec;
        return r;
    endfunction

    // APB write followed by a read back of the same register.
    task automatic write_reg(input logic [3:0] addr, input logic val);
        @(negedge i_clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = addr;
        pwdata = {31'($urandom_range(0, 32'h7FFF_FFFF)), val};
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        pwrite = 1'b0;
        penable = 1'b0;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata[0] !== val) begin
            flag_error($sformatf("register at 0x%0h read %0h, expected %0h",
                                 addr, prdata[0], val));
        end
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
    endtask

    task automatic program_config(input logic t, input logic v, input logic c);
        write_reg(ADDR_TEXT_FORMAT, t);
        write_reg(ADDR_VALID_ONLY, v);
        write_reg(ADDR_CRC_ENABLE, c);
        cfg_text = t;
        cfg_vonly = v;
        cfg_crc = c;
        setting_count++;
    endtask

    // Offers one message and queues its burst once the transaction happens.
    task automatic send_message(input logic [10:0] id, input logic used,
                                input logic [3:0] flen, input logic [7:0] idx,
                                input logic [63:0] payload, input int exp_len,
                                input logic [215:0] exp_vec);
        @(negedge i_clk);
        s_axis_tdata = {1'b0, payload, idx, flen, id};
        s_axis_tuser = used;
        s_axis_tvalid = 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        if (exp_len == 0) begin
            predict_message(id, used, flen, idx, payload);
        end else begin
            for (int k = 0; k < exp_len; k++) begin
                pending_bytes.push_back({k == exp_len - 1, exp_vec[8*(exp_len-1-k) +: 8]});
            end
        end
        msg_count++;
    endtask

    // Drops tvalid and puts garbage on the data lines while it idles.
    task automatic idle_in(input int n);
        if (n > 0) begin
            @(negedge i_clk);
            s_axis_tvalid = 1'b0;
            s_axis_tdata = 88'({$urandom, $urandom, $urandom});
            s_axis_tuser = 1'($urandom_range(0, 1));
            repeat (n - 1) @(negedge i_clk);
        end
    endtask

    // The block is idle once every expected byte has left it.
    task automatic wait_idle();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (pending_bytes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Output side: random stalls, none in the quiet phase, and one long
    // hold-off on request so that the block backs up into its input.
    initial begin
        int stall_left;
        bit hold_done;
        stall_left = 0;
        hold_done = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req && !hold_done) begin
                m_axis_tready = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
                hold_done = 1'b1;
            end else if (stall_left > 0) begin
                m_axis_tready = 1'b0;
                stall_left--;
            end else begin
                m_axis_tready = 1'b1;
                stall_left = quiet_phase ? 0 : pick_gap();
            end
        end
    end

    always @(posedge i_clk) begin : check_out
        logic [8:0] want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_bytes.size() == 0) begin
                flag_error($sformatf("unexpected byte %02h last %0b",
                                     m_axis_tdata, m_axis_tlast));
            end else begin
                want = pending_bytes.pop_front();
                if (m_axis_tdata !== want[7:0] || m_axis_tlast !== want[8]) begin
                    flag_error($sformatf("byte %0d: got %02h last %0b, expected %02h last %0b",
                                         byte_count, m_axis_tdata, m_axis_tlast,
                                         want[7:0], want[8]));
                end
            end
            byte_count++;
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Timed out after %0d cycles with %0d bytes outstanding.",
                 cycle_count, pending_bytes.size());
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        msg_row_t   row;
        int         offset;
        int         quiet_pick;
        logic [2:0] combo;
        logic [3:0] flen;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset configuration: binary, all eight data bytes, no CRC.
        directed_rows.push_back(make_row(0, 0, 0, 11'h000, 0, 4'd0, 8'h00, 64'h0,
                                13, {8'hBE, 8'hEF, 8'h00, 8'h00, 8'h00, 64'h0}));
        directed_rows.push_back(make_row(0, 0, 0, 11'h7FF, 1, 4'd8, 8'hFF,
                                64'hFFFF_FFFF_FFFF_FFFF, 0, '0));
        // With valid_only clear all eight bytes go out regardless of length.
        directed_rows.push_back(make_row(0, 0, 0, 11'h555, 0, 4'd3, 8'hA5,
                                64'h0123_4567_89AB_CDEF, 0, '0));
        // Index used with zero length: the payload count would go negative.
        directed_rows.push_back(make_row(0, 1, 0, 11'h7FF, 1, 4'd0, 8'hFF,
                                64'h1122_3344_5566_7788, 5,
                                {8'hBE, 8'hEF, 8'hFF, 8'h07, 8'hFF}));
        directed_rows.push_back(make_row(0, 1, 0, 11'h2AA, 1, 4'd1, 8'h3C,
                                64'hDEAD_BEEF_CAFE_F00D, 0, '0));
        // Index unused: the index byte goes out as zero.
        directed_rows.push_back(make_row(0, 1, 0, 11'h0F0, 0, 4'd8, 8'h99,
                                64'h8877_6655_4433_2211, 0, '0));
        // Lengths above eight saturate, with and without the index byte.
        directed_rows.push_back(make_row(0, 1, 0, 11'h00F, 0, 4'd15, 8'h00,
                                64'hA5A5_5A5A_F0F0_0F0F, 0, '0));
        directed_rows.push_back(make_row(0, 1, 0, 11'h400, 1, 4'd15, 8'h80,
                                64'h0102_0304_0506_0708, 0, '0));
        directed_rows.push_back(make_row(0, 1, 0, 11'h001, 0, 4'd9, 8'h5A,
                                64'h7F80_01FE_55AA_C33C, 0, '0));
        // Binary CRC over id, index and data only.
        directed_rows.push_back(make_row(0, 1, 1, 11'h123, 1, 4'd4, 8'h42,
                                64'h0000_0000_00C0_FFEE, 0, '0));
        directed_rows.push_back(make_row(0, 1, 1, 11'h000, 0, 4'd0, 8'hFF, 64'h0, 0, '0));
        directed_rows.push_back(make_row(0, 1, 1, 11'h7FF, 0, 4'd8, 8'h00,
                                64'hFFFF_FFFF_FFFF_FFFF, 0, '0));
        // Hex text.
        directed_rows.push_back(make_row(1, 0, 0, 11'h123, 1, 4'd2, 8'h4C, 64'h0, 0, '0));
        directed_rows.push_back(make_row(1, 1, 0, 11'h7FF, 1, 4'd1, 8'hAB,
                                64'h1234_5678_9ABC_DEF0, 8, "7FF AB \n"));
        directed_rows.push_back(make_row(1, 1, 0, 11'h7FF, 0, 4'd0, 8'hFF,
                                64'h1234_5678_9ABC_DEF0, 8, "7FF 00 \n"));
        directed_rows.push_back(make_row(1, 1, 0, 11'h000, 0, 4'd15, 8'h00,
                                64'hFEDC_BA98_7654_3210, 0, '0));
        // Text CRC over the characters, spaces included, up to the last digit.
        directed_rows.push_back(make_row(1, 1, 1, 11'h3C5, 1, 4'd0, 8'h81, 64'h0, 0, '0));
        directed_rows.push_back(make_row(1, 1, 1, 11'h7FF, 0, 4'd8, 8'hFF,
                                64'hFFFF_FFFF_FFFF_FFFF, 0, '0));
        directed_rows.push_back(make_row(1, 1, 1, 11'h000, 1, 4'd9, 8'h00, 64'h0, 0, '0));
        directed_rows.push_back(make_row(1, 0, 1, 11'h7FF, 1, 4'd8, 8'hFF,
                                64'hFFFF_FFFF_FFFF_FFFF, 0, '0));
        directed_rows.push_back(make_row(0, 0, 1, 11'h7FF, 1, 4'd8, 8'hFF,
                                64'hFFFF_FFFF_FFFF_FFFF, 0, '0));

        foreach (directed_rows[r]) begin
            row = directed_rows[r];
            if (row.text != cfg_text || row.vonly != cfg_vonly || row.crc != cfg_crc) begin
                wait_idle();
                program_config(row.text, row.vonly, row.crc);
            end
            send_message(row.id, row.used, row.flen, row.idx, row.payload,
                         row.exp_len, row.exp_vec);
            idle_in(pick_gap());
        end

        // Random traffic: every register setting once, in turn from a random start,
        // one phase without any idling.
        offset = $urandom_range(0, 7);
        quiet_pick = $urandom_range(0, 7);
        for (int p = 0; p < 8; p++) begin
            combo = 3'((p + offset) % 8);
            wait_idle();
            quiet_phase = (p == quiet_pick);
            program_config(combo[0], combo[1], combo[2]);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                flen = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(9, 15))
                                                   : 4'($urandom_range(0, 8));
                send_message(11'($urandom_range(0, 2047)), 1'($urandom_range(0, 1)), flen,
                             8'($urandom_range(0, 255)), {$urandom, $urandom}, 0, '0);
                if (p == 3 && k == 5) hold_req = 1'b1;
                idle_in(quiet_phase ? 0 : pick_gap());
            end
        end
        wait_idle();

        $display("Covered %0d messages (%0d from the table) and %0d output bytes,",
                 msg_count, directed_rows.size(), byte_count);
        $display("over %0d register settings, one long output hold-off; %0d mismatches.",
                 setting_count, err_cnt);
        if (err_cnt == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

/* sim.f */
src/cms_pkg.sv
src/cms_crc8.sv
src/can_message_serializer.sv
verif/tb.sv
